### design/depth_map_hole_fill_core_defines.svh
// Assertion macros for the depth map hole fill core.
`ifndef DEPTH_MAP_HOLE_FILL_CORE_DEFINES_SVH
`define DEPTH_MAP_HOLE_FILL_CORE_DEFINES_SVH

// Concurrent check on aclk, off while aresetn is low.
`define DMHF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Concurrent check on aclk that also holds through reset.
`define DMHF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/dmhf_pkg.sv
// Shared types and constants of the depth map hole fill core.
package dmhf_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_DEPTH_BITS = 32;
    localparam int DEPTH_BITS_MAX = 32;
    localparam int DEPTH_FIELD_W  = 32;
    localparam int SUM_MAX_W      = DEPTH_BITS_MAX + 3;
    localparam int NB_COUNT       = 8;
    localparam int COUNT_W        = 4;
    localparam int REM_W          = COUNT_W - 1;
    localparam int FILL_MIN_COUNT = 3;
    localparam int WIN_TAPS       = 6;
    localparam int DIV_BITS       = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_W      = 12;
    localparam int OROW_W     = 11;
    localparam int MAX_HEIGHT = 2048;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [DEPTH_FIELD_W-1:0] depth;
    } in_item_t;

    typedef struct packed {
        logic [DEPTH_FIELD_W-1:0] filled_depth;
        logic                     was_filled;
        logic                     last_pixel;
    } out_item_t;

    // value is the neighbour sum when fill is set, else the centre pixel
    typedef struct packed {
        logic [SUM_MAX_W-1:0] value;
        logic [COUNT_W-1:0]   cnt;
        logic                 fill;
        logic                 last;
    } job_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_status_t;

endpackage

### design/dmhf_front.sv
// Front end: frame counters, row stores, 3x3 window and pixel classification.
module dmhf_front #(
    parameter int MAX_WIDTH  = dmhf_pkg::DEF_MAX_WIDTH,
    parameter int DEPTH_BITS = dmhf_pkg::DEF_DEPTH_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dmhf_pkg::in_item_t              s_data,
    input  logic                            cfg_wr_en,
    input  logic [dmhf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmhf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  dmhf_pkg::queue_status_t         q_status,
    output logic                            push,
    output dmhf_pkg::job_t                  push_job
);
    import dmhf_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WEFF_W    = $clog2(MAX_WIDTH + 1);
    localparam int CFG_EXT_W = CFG_DATA_W + 1;
    localparam int SUM_W     = DEPTH_BITS + 3;

    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [OROW_W-1:0]     out_row_reg, out_row_next;
    logic [DEPTH_BITS-1:0] win_reg [WIN_TAPS];
    logic [DEPTH_BITS-1:0] win_next [WIN_TAPS];

    logic [DEPTH_BITS-1:0] upper_mem [MAX_WIDTH];
    logic [DEPTH_BITS-1:0] middle_mem [MAX_WIDTH];
    logic [DEPTH_BITS-1:0] upper_rd_reg, middle_rd_reg;
    logic [COL_W-1:0]      rd_addr;
    logic                  mem_we;

    logic [WEFF_W-1:0]     w_eff;
    logic [ROW_W-1:0]      h_eff;
    logic [OROW_W-1:0]     h_m1;
    logic                  in_recv, step, advance, emit, last, fill, frame_end, col_wrap;
    logic                  left_ok, right_ok;
    logic [DEPTH_BITS-1:0] pix, top, mid, centre;
    logic [DEPTH_BITS-1:0] nb [NB_COUNT];
    logic [SUM_W-1:0]      sum;
    logic [COUNT_W-1:0]    cnt;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WEFF_W'(1);
        end else if (CFG_EXT_W'(width_reg) > CFG_EXT_W'(MAX_WIDTH)) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = ROW_W'(1);
        end else if (height_reg > ROW_W'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    assign h_m1     = OROW_W'(h_eff - ROW_W'(1));
    assign s_ready  = !q_status.full;
    assign step     = s_valid && s_ready;
    assign in_recv  = row_reg < h_eff;
    assign advance  = step && !(in_recv && (s_data.operation == OP_DRAIN));
    assign pix      = in_recv ? s_data.depth[DEPTH_BITS-1:0] : '0;
    assign top      = (row_reg >= ROW_W'(2)) ? upper_rd_reg : '0;
    assign mid      = (row_reg != '0) ? middle_rd_reg : '0;
    assign emit     = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
    assign left_ok  = out_col_reg != '0;
    assign right_ok = col_reg != '0;
    assign centre   = win_reg[1];
    assign col_wrap = (WEFF_W'(col_reg) + WEFF_W'(1)) >= w_eff;
    assign last     = (out_row_reg == h_m1) && (WEFF_W'(out_col_reg) == (w_eff - WEFF_W'(1)));

    always_comb begin
        nb[0] = win_reg[0];
        nb[1] = win_reg[2];
        nb[2] = left_ok ? win_reg[3] : '0;
        nb[3] = left_ok ? win_reg[4] : '0;
        nb[4] = left_ok ? win_reg[5] : '0;
        nb[5] = right_ok ? top : '0;
        nb[6] = right_ok ? mid : '0;
        nb[7] = right_ok ? pix : '0;
        sum = '0;
        cnt = '0;
        for (int k = 0; k < NB_COUNT; k++) begin
            sum = sum + SUM_W'(nb[k]);
            cnt = cnt + COUNT_W'(nb[k] != '0);
        end
    end

    assign fill      = (centre == '0) && (cnt > COUNT_W'(FILL_MIN_COUNT));
    assign push      = advance && emit;
    assign frame_end = push && last;
    assign mem_we    = aresetn && advance && !frame_end;

    always_comb begin
        push_job.value = fill ? SUM_MAX_W'(sum) : SUM_MAX_W'(centre);
        push_job.cnt   = cnt;
        push_job.fill  = fill;
        push_job.last  = last;
    end

    always_comb begin
        logic restart;
        restart      = 1'b0;
        width_next   = width_reg;
        height_next  = height_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        win_next     = win_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    width_next = cfg_wr_data;
                    restart    = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    height_next = cfg_wr_data;
                    restart     = 1'b1;
                end
            endcase
        end else if (frame_end) begin
            restart = 1'b1;
        end else if (advance) begin
            win_next[3] = win_reg[0];
            win_next[4] = win_reg[1];
            win_next[5] = win_reg[2];
            win_next[0] = top;
            win_next[1] = mid;
            win_next[2] = pix;
            if (col_wrap) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
            if (push) begin
                if ((WEFF_W'(out_col_reg) + WEFF_W'(1)) >= w_eff) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
        if (restart) begin
            col_next     = '0;
            row_next     = '0;
            out_col_next = '0;
            out_row_next = '0;
            for (int t = 0; t < WIN_TAPS; t++) begin
                win_next[t] = '0;
            end
        end
    end

    assign rd_addr = aresetn ? col_next : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= CFG_DATA_W'(1);
            height_reg  <= CFG_DATA_W'(1);
            col_reg     <= '0;
            row_reg     <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int t = 0; t < WIN_TAPS; t++) begin
                win_reg[t] <= '0;
            end
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            win_reg     <= win_next;
        end
    end

    // row stores, read one column ahead; same-column write forwarded
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            upper_mem[col_reg]  <= mid;
            middle_mem[col_reg] <= pix;
        end
        if (mem_we && (rd_addr == col_reg)) begin
            upper_rd_reg  <= mid;
            middle_rd_reg <= pix;
        end else begin
            upper_rd_reg  <= upper_mem[rd_addr];
            middle_rd_reg <= middle_mem[rd_addr];
        end
    end

endmodule

### design/dmhf_queue.sv
// Short job queue between the front end and the back end.
module dmhf_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  dmhf_pkg::job_t          push_job,
    input  logic                    pop,
    output dmhf_pkg::job_t          q_job,
    output dmhf_pkg::queue_status_t q_status
);
    import dmhf_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_job             = entry_reg[rd_ptr_reg];
    assign q_status.full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_status.nonempty = count_reg != '0;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

### design/dmhf_back.sv
// Back end: neighbour mean divider and output register.
module dmhf_back #(
    parameter int DEPTH_BITS = dmhf_pkg::DEF_DEPTH_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dmhf_pkg::job_t          q_job,
    input  dmhf_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output dmhf_pkg::out_item_t     m_data
);
    import dmhf_pkg::*;

    localparam int SUM_W     = DEPTH_BITS + 3;
    localparam int DIV_STEPS = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_RESULT = 3'b100
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [PAD_W-1:0]    div_sh_reg, div_sh_next;
    logic [REM_W-1:0]    div_rem_reg, div_rem_next;
    logic [COUNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                last_reg, last_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic [DIV_BITS-1:0] digits, qbits;
    logic [REM_W-1:0]    rem_out;
    logic                out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign digits   = div_sh_reg[PAD_W-1 -: DIV_BITS];

    // one quotient digit of DIV_BITS bits per cycle, divisor is 4..8
    always_comb begin
        logic [COUNT_W-1:0] t;
        logic [REM_W-1:0]   r;
        r = div_rem_reg;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            t = {r, digits[i]};
            if (t >= div_cnt_reg) begin
                t        = t - div_cnt_reg;
                qbits[i] = 1'b1;
            end else begin
                qbits[i] = 1'b0;
            end
            r = t[REM_W-1:0];
        end
        rem_out = r;
    end

    always_comb begin
        state_next   = state_reg;
        div_sh_next  = div_sh_reg;
        div_rem_next = div_rem_reg;
        div_cnt_next = div_cnt_reg;
        step_next    = step_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        pop          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_status.nonempty) begin
                    if (q_job.fill) begin
                        pop          = 1'b1;
                        div_sh_next  = PAD_W'(q_job.value[SUM_W-1:0]);
                        div_rem_next = '0;
                        div_cnt_next = q_job.cnt;
                        step_next    = STEP_W'(DIV_STEPS - 1);
                        last_next    = q_job.last;
                        state_next   = ST_DIV;
                    end else if (out_free) begin
                        pop                      = 1'b1;
                        m_valid_next             = 1'b1;
                        m_data_next.filled_depth = DEPTH_FIELD_W'(q_job.value[DEPTH_BITS-1:0]);
                        m_data_next.was_filled   = 1'b0;
                        m_data_next.last_pixel   = q_job.last;
                    end
                end
            end
            ST_DIV: begin
                div_sh_next  = {div_sh_reg[PAD_W-DIV_BITS-1:0], qbits};
                div_rem_next = rem_out;
                if (step_reg == '0) begin
                    state_next = ST_RESULT;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.filled_depth = DEPTH_FIELD_W'(div_sh_reg[DEPTH_BITS-1:0]);
                    m_data_next.was_filled   = 1'b1;
                    m_data_next.last_pixel   = last_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_sh_reg  <= div_sh_next;
        div_rem_reg <= div_rem_next;
        div_cnt_reg <= div_cnt_next;
        step_reg    <= step_next;
        last_reg    <= last_next;
        m_data_reg  <= m_data_next;
    end

endmodule

### design/depth_map_hole_fill_core.sv
// Top level of the depth map hole fill core.
//
// Depth pixels enter on the s_ channel in raster order (operation pixel); a
// drain item flushes pending outputs once the whole frame has arrived, and a
// drain sent earlier is taken and dropped. One result per pixel leaves on the
// m_ channel in raster order, with was_filled on holes replaced by the mean
// of more than three non-empty neighbours and last_pixel on the frame's end.
// Results lag the input by image_width + 1 items. The item that completes a
// result pushes a job into the queue; the back end moves it into the m_
// output register, a filled hole first through the DIV_STEPS steps of the
// digit-serial divider (DIV_STEPS = ceil((DEPTH_BITS + 3) / 8), 5 at 32 bits).
// The front end takes one item per cycle while its four-entry job queue has
// room; pass-through results drain at one per cycle while m_ready allows and
// no filled hole holds the back end through its divider steps and ST_RESULT.
// Image size is written on the cfg_ port while idle; any write restarts the
// frame. Reset clears counters, window, queue and output register; the row
// stores are not cleared and are never read before written in a frame.
// A stalled m_ready holds the result; once the queue fills, s_ready drops.
module depth_map_hole_fill_core #(
    parameter int MAX_WIDTH  = dmhf_pkg::DEF_MAX_WIDTH,
    parameter int DEPTH_BITS = dmhf_pkg::DEF_DEPTH_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dmhf_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output dmhf_pkg::out_item_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [dmhf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmhf_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import dmhf_pkg::*;

    logic          push, pop;
    job_t          push_job, q_job;
    queue_status_t q_status;

    dmhf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job)
    );

    dmhf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_job    (q_job),
        .q_status (q_status)
    );

    dmhf_back #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_job    (q_job),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### design/dmhf_checker.sv
// Port-level assertions for the depth map hole fill core, bound to the top.
`include "depth_map_hole_fill_core_defines.svh"

module dmhf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dmhf_pkg::out_item_t m_data
);
    import dmhf_pkg::*;

    `DMHF_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result item dropped while stalled")
    `DMHF_ASSERT(a_out_stable, m_valid && !m_ready |=> $stable(m_data), "stalled result changed")
    `DMHF_ASSERT(a_fill_nonzero, m_valid && m_data.was_filled |-> m_data.filled_depth != '0, "filled hole came out empty")
    `DMHF_ASSERT_RST(a_reset_clear, !aresetn |=> !m_valid && s_ready, "reset left output or queue busy")

endmodule

bind depth_map_hole_fill_core dmhf_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
